/* sv/dltq_pkg.sv */
// dltq_pkg: shared types and constants of the delta list timer queue
// used by dltq_mem, dltq_ctrl and delta_list_timer_queue; no dependencies
`default_nettype none

package dltq_pkg;

   // most result items that one input item may cause
   localparam int MAX_RESULTS = 16;
   localparam int CNT_WIDTH   = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      ACT_ADD        = 2'd0,
      ACT_CANCEL     = 2'd1,
      ACT_CANCEL_ALL = 2'd2,
      ACT_TICK       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_FIRED     = 2'd0,
      KIND_CANCELLED = 2'd1,
      KIND_ACCEPTED  = 2'd2,
      KIND_REJECTED  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADD_POP,
      ST_ADD_WALK,
      ST_ADD_LINK,
      ST_ADD_PREV,
      ST_CAN_WALK,
      ST_CAN_FIX,
      ST_CAN_FREE,
      ST_LOOP,
      ST_EMIT_LAST
   } state_type;

   // per-field write enables of the slot memory
   typedef struct packed {
      logic delta;
      logic key;
      logic tag;
      logic link;
   } wr_en_type;

endpackage

`default_nettype wire

/* sv/dltq_mem.sv */
// dltq_mem: slot memory (delta, key, tag, link) with one write port and
// one registered read port; uses dltq_pkg for the write enable struct
`default_nettype none

module dltq_mem #(
   parameter int SLOTS       = 16,
   parameter int DELAY_WIDTH = 16,
   parameter int KEY_WIDTH   = 16,
   parameter int TAG_WIDTH   = 32
) (
   input  wire                              clock,
   input  wire dltq_pkg::wr_en_type         wr_en,
   input  wire  [$clog2(SLOTS)-1:0]         wr_addr,
   input  wire  [DELAY_WIDTH-1:0]           wr_delta,
   input  wire  [KEY_WIDTH-1:0]             wr_key,
   input  wire  [TAG_WIDTH-1:0]             wr_tag,
   input  wire  [$clog2(SLOTS+1)-1:0]       wr_link,
   input  wire                              rd_en,
   input  wire  [$clog2(SLOTS)-1:0]         rd_addr,
   output logic [DELAY_WIDTH-1:0]           rd_delta,
   output logic [KEY_WIDTH-1:0]             rd_key,
   output logic [TAG_WIDTH-1:0]             rd_tag,
   output logic [$clog2(SLOTS+1)-1:0]       rd_link
);

   localparam int LW = $clog2(SLOTS + 1);

   logic [DELAY_WIDTH-1:0] delta_mem [SLOTS];
   logic [KEY_WIDTH-1:0]   key_mem   [SLOTS];
   logic [TAG_WIDTH-1:0]   tag_mem   [SLOTS];
   logic [LW-1:0]          link_mem  [SLOTS];

   // write port, one field enable each
   always_ff @(posedge clock) begin
      if (wr_en.delta) delta_mem[wr_addr] <= wr_delta;
      if (wr_en.key)   key_mem[wr_addr]   <= wr_key;
      if (wr_en.tag)   tag_mem[wr_addr]   <= wr_tag;
      if (wr_en.link)  link_mem[wr_addr]  <= wr_link;
   end

   // registered read, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_delta <= delta_mem[rd_addr];
         rd_key   <= key_mem[rd_addr];
         rd_tag   <= tag_mem[rd_addr];
         rd_link  <= link_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/dltq_ctrl.sv */
// dltq_ctrl: sequencer that walks and edits the delta list held in dltq_mem
// uses dltq_pkg for actions, result kinds, states and write enables
`default_nettype none

module dltq_ctrl #(
   parameter int SLOTS       = 16,
   parameter int DELAY_WIDTH = 16,
   parameter int KEY_WIDTH   = 16,
   parameter int TAG_WIDTH   = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   // input items
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire dltq_pkg::action_type        req_action,
   input  wire  [DELAY_WIDTH-1:0]           req_delay,
   input  wire  [KEY_WIDTH-1:0]             req_key,
   input  wire  [TAG_WIDTH-1:0]             req_tag,
   // result items toward the output register
   input  wire                              out_free,
   output logic                             emit_valid,
   output logic                             emit_last,
   output dltq_pkg::kind_type               emit_kind,
   output logic [KEY_WIDTH-1:0]             emit_key,
   output logic [TAG_WIDTH-1:0]             emit_tag,
   output logic [$clog2(SLOTS+1)-1:0]       pending_count,
   // slot memory
   output dltq_pkg::wr_en_type              wr_en,
   output logic [$clog2(SLOTS)-1:0]         wr_addr,
   output logic [DELAY_WIDTH-1:0]           wr_delta,
   output logic [KEY_WIDTH-1:0]             wr_key,
   output logic [TAG_WIDTH-1:0]             wr_tag,
   output logic [$clog2(SLOTS+1)-1:0]       wr_link,
   output logic                             rd_en,
   output logic [$clog2(SLOTS)-1:0]         rd_addr,
   input  wire  [DELAY_WIDTH-1:0]           rd_delta,
   input  wire  [KEY_WIDTH-1:0]             rd_key,
   input  wire  [TAG_WIDTH-1:0]             rd_tag,
   input  wire  [$clog2(SLOTS+1)-1:0]       rd_link
);

   localparam int AW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 1);
   localparam int CW = dltq_pkg::CNT_WIDTH;
   localparam logic [LW-1:0] NIL = LW'(SLOTS);

   dltq_pkg::state_type  state_ff, state_in;
   dltq_pkg::action_type act_ff, act_in;
   dltq_pkg::kind_type   hold_kind_ff, hold_kind_in;
   logic [DELAY_WIDTH-1:0] remain_ff, remain_in;
   logic [DELAY_WIDTH-1:0] cdelta_ff, cdelta_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [TAG_WIDTH-1:0]   tag_ff, tag_in;
   logic [KEY_WIDTH-1:0]   hold_key_ff, hold_key_in;
   logic [TAG_WIDTH-1:0]   hold_tag_ff, hold_tag_in;
   logic                   hold_v_ff, hold_v_in;
   logic                   first_ff, first_in;
   logic [LW-1:0]          head_ff, head_in;
   logic [LW-1:0]          free_ff, free_in;
   logic [LW-1:0]          prev_ff, prev_in;
   logic [LW-1:0]          cur_ff, cur_in;
   logic [LW-1:0]          nw_ff, nw_in;
   logic [LW-1:0]          count_ff, count_in;
   logic [CW-1:0]          n_ff, n_in;
   logic                   take;
   logic [CW-1:0]          n_next;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dltq_pkg::ST_INIT;
         head_ff   <= NIL;
         free_ff   <= '0;
         cur_ff    <= '0;
         count_ff  <= '0;
         hold_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         free_ff   <= free_in;
         cur_ff    <= cur_in;
         count_ff  <= count_in;
         hold_v_ff <= hold_v_in;
      end
   end

   // working registers of the current item
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      remain_ff    <= remain_in;
      cdelta_ff    <= cdelta_in;
      key_ff       <= key_in;
      tag_ff       <= tag_in;
      hold_kind_ff <= hold_kind_in;
      hold_key_ff  <= hold_key_in;
      hold_tag_ff  <= hold_tag_in;
      first_ff     <= first_in;
      prev_ff      <= prev_in;
      nw_ff        <= nw_in;
      n_ff         <= n_in;
   end

   assign n_next = CW'(n_ff + 1'b1);

   // due test at the list head: a tick first takes one off the head
   always_comb begin
      if (act_ff == dltq_pkg::ACT_CANCEL_ALL) take = 1'b1;
      else if (first_ff)                      take = (rd_delta <= DELAY_WIDTH'(1));
      else                                    take = (rd_delta == '0);
   end

   // next state and memory accesses; no read ever hits the entry written
   // in the same cycle, so no forwarding is needed
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      remain_in    = remain_ff;
      cdelta_in    = cdelta_ff;
      key_in       = key_ff;
      tag_in       = tag_ff;
      hold_kind_in = hold_kind_ff;
      hold_key_in  = hold_key_ff;
      hold_tag_in  = hold_tag_ff;
      hold_v_in    = hold_v_ff;
      first_in     = first_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      nw_in        = nw_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      req_ready    = 1'b0;
      emit_valid   = 1'b0;
      emit_last    = 1'b0;
      wr_en        = '0;
      wr_addr      = cur_ff[AW-1:0];
      wr_delta     = '0;
      wr_key       = key_ff;
      wr_tag       = tag_ff;
      wr_link      = free_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_link[AW-1:0];

      unique case (state_ff)
         // build the free chain, one slot a cycle
         dltq_pkg::ST_INIT: begin
            wr_en.link = 1'b1;
            wr_link    = LW'(cur_ff + 1'b1);
            cur_in     = LW'(cur_ff + 1'b1);
            if (cur_ff == LW'(SLOTS - 1)) state_in = dltq_pkg::ST_IDLE;
         end

         dltq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in      = req_action;
               remain_in   = (req_delay == '0) ? DELAY_WIDTH'(1) : req_delay;
               key_in      = req_key;
               tag_in      = req_tag;
               hold_key_in = req_key;
               hold_tag_in = req_tag;
               hold_v_in   = 1'b0;
               first_in    = 1'b1;
               n_in        = '0;
               prev_in     = NIL;
               cur_in      = head_ff;
               rd_addr     = head_ff[AW-1:0];
               case (req_action)
                  dltq_pkg::ACT_ADD: begin
                     if (free_ff == NIL) begin
                        hold_kind_in = dltq_pkg::KIND_REJECTED;
                        hold_v_in    = 1'b1;
                        state_in     = dltq_pkg::ST_EMIT_LAST;
                     end else begin
                        hold_kind_in = dltq_pkg::KIND_ACCEPTED;
                        rd_en        = 1'b1;
                        rd_addr      = free_ff[AW-1:0];
                        state_in     = dltq_pkg::ST_ADD_POP;
                     end
                  end
                  dltq_pkg::ACT_CANCEL: begin
                     if (head_ff != NIL) begin
                        rd_en    = 1'b1;
                        state_in = dltq_pkg::ST_CAN_WALK;
                     end
                  end
                  default: begin
                     if (head_ff != NIL) begin
                        rd_en    = 1'b1;
                        state_in = dltq_pkg::ST_LOOP;
                     end
                  end
               endcase
            end
         end

         // take a slot off the free chain
         dltq_pkg::ST_ADD_POP: begin
            nw_in   = free_ff;
            free_in = rd_link;
            if (head_ff == NIL) begin
               state_in = dltq_pkg::ST_ADD_LINK;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff[AW-1:0];
               state_in = dltq_pkg::ST_ADD_WALK;
            end
         end

         // skip entries due at or before the new alarm
         dltq_pkg::ST_ADD_WALK: begin
            if (rd_delta <= remain_ff) begin
               remain_in = remain_ff - rd_delta;
               prev_in   = cur_ff;
               cur_in    = rd_link;
               if (rd_link == NIL) begin
                  state_in = dltq_pkg::ST_ADD_LINK;
               end else begin
                  rd_en = 1'b1;
               end
            end else begin
               wr_en.delta = 1'b1;
               wr_delta    = rd_delta - remain_ff;
               state_in    = dltq_pkg::ST_ADD_LINK;
            end
         end

         dltq_pkg::ST_ADD_LINK: begin
            wr_en    = '{delta: 1'b1, key: 1'b1, tag: 1'b1, link: 1'b1};
            wr_addr  = nw_ff[AW-1:0];
            wr_delta = remain_ff;
            wr_link  = cur_ff;
            state_in = dltq_pkg::ST_ADD_PREV;
         end

         dltq_pkg::ST_ADD_PREV: begin
            if (prev_ff != NIL) begin
               wr_en.link = 1'b1;
               wr_addr    = prev_ff[AW-1:0];
               wr_link    = nw_ff;
            end else begin
               head_in = nw_ff;
            end
            count_in  = LW'(count_ff + 1'b1);
            hold_v_in = 1'b1;
            state_in  = dltq_pkg::ST_EMIT_LAST;
         end

         // search for the first matching key and unlink it
         dltq_pkg::ST_CAN_WALK: begin
            if (rd_key == key_ff) begin
               cdelta_in    = rd_delta;
               hold_kind_in = dltq_pkg::KIND_CANCELLED;
               hold_key_in  = rd_key;
               hold_tag_in  = rd_tag;
               hold_v_in    = 1'b1;
               // prev now carries the successor
               prev_in      = rd_link;
               if (prev_ff != NIL) begin
                  wr_en.link = 1'b1;
                  wr_addr    = prev_ff[AW-1:0];
                  wr_link    = rd_link;
               end else begin
                  head_in = rd_link;
               end
               if (rd_link != NIL) begin
                  rd_en    = 1'b1;
                  state_in = dltq_pkg::ST_CAN_FIX;
               end else begin
                  state_in = dltq_pkg::ST_CAN_FREE;
               end
            end else begin
               prev_in = cur_ff;
               cur_in  = rd_link;
               if (rd_link == NIL) begin
                  state_in = dltq_pkg::ST_IDLE;
               end else begin
                  rd_en = 1'b1;
               end
            end
         end

         // successor takes over the removed delay
         dltq_pkg::ST_CAN_FIX: begin
            wr_en.delta = 1'b1;
            wr_addr     = prev_ff[AW-1:0];
            wr_delta    = rd_delta + cdelta_ff;
            state_in    = dltq_pkg::ST_CAN_FREE;
         end

         dltq_pkg::ST_CAN_FREE: begin
            wr_en.link = 1'b1;
            free_in    = cur_ff;
            count_in   = LW'(count_ff - 1'b1);
            state_in   = dltq_pkg::ST_EMIT_LAST;
         end

         // pop the head for cancel-all or tick; the item held from the
         // previous pop goes out once we know it is not the last
         dltq_pkg::ST_LOOP: begin
            if (!take) begin
               if (first_ff) begin
                  wr_en.delta = 1'b1;
                  wr_delta    = rd_delta - DELAY_WIDTH'(1);
               end
               state_in = hold_v_ff ? dltq_pkg::ST_EMIT_LAST : dltq_pkg::ST_IDLE;
            end else if (!hold_v_ff || out_free) begin
               emit_valid   = hold_v_ff;
               head_in      = rd_link;
               wr_en.link   = 1'b1;
               free_in      = cur_ff;
               count_in     = LW'(count_ff - 1'b1);
               hold_kind_in = (act_ff == dltq_pkg::ACT_CANCEL_ALL) ?
                              dltq_pkg::KIND_CANCELLED : dltq_pkg::KIND_FIRED;
               hold_key_in  = rd_key;
               hold_tag_in  = rd_tag;
               hold_v_in    = 1'b1;
               first_in     = 1'b0;
               n_in         = n_next;
               cur_in       = rd_link;
               if (rd_link != NIL && n_next < CW'(dltq_pkg::MAX_RESULTS)) begin
                  rd_en = 1'b1;
               end else begin
                  state_in = dltq_pkg::ST_EMIT_LAST;
               end
            end
         end

         dltq_pkg::ST_EMIT_LAST: begin
            if (out_free) begin
               emit_valid = 1'b1;
               emit_last  = 1'b1;
               hold_v_in  = 1'b0;
               state_in   = dltq_pkg::ST_IDLE;
            end
         end

         default: state_in = dltq_pkg::ST_IDLE;
      endcase
   end

   assign emit_kind     = hold_kind_ff;
   assign emit_key      = hold_key_ff;
   assign emit_tag      = hold_tag_ff;
   assign pending_count = count_ff;

endmodule

`default_nettype wire

/* sv/delta_list_timer_queue.sv */
// Timer queue of SLOTS alarms kept as a delta-sorted linked list in a slot
// memory with a registered read port. One item is worked at a time: an add
// or cancel walks the list at one entry per cycle, and cancel-all or tick
// pop one alarm per cycle while the output side does not stall. After reset
// the free chain is built over all slots before the first item is taken.
// depends on dltq_pkg, dltq_mem and dltq_ctrl
`default_nettype none

module delta_list_timer_queue #(
   parameter int SLOTS       = 16,
   parameter int DELAY_WIDTH = 16,
   parameter int KEY_WIDTH   = 16,
   parameter int TAG_WIDTH   = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // delay, key, tag from bit 0 up, zero padded to bytes
   input  wire  [((DELAY_WIDTH+KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0] req_tdata,
   // action
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // alarm_key, alarm_tag from bit 0 up, zero padded to bytes
   output logic [((KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int AW  = $clog2(SLOTS);
   localparam int LW  = $clog2(SLOTS + 1);
   localparam int RDW = ((KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8;

   dltq_pkg::wr_en_type  wr_en;
   dltq_pkg::kind_type   emit_kind;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [DELAY_WIDTH-1:0] wr_delta, rd_delta;
   logic [KEY_WIDTH-1:0]   wr_key, rd_key, emit_key;
   logic [TAG_WIDTH-1:0]   wr_tag, rd_tag, emit_tag;
   logic [LW-1:0]          wr_link, rd_link, pending_count;
   logic                   rd_en, emit_valid, emit_last, out_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff;
   dltq_pkg::kind_type   rsp_kind_ff;
   logic [KEY_WIDTH-1:0] rsp_key_ff;
   logic [TAG_WIDTH-1:0] rsp_tag_ff;

   dltq_ctrl #(
      .SLOTS(SLOTS), .DELAY_WIDTH(DELAY_WIDTH), .KEY_WIDTH(KEY_WIDTH), .TAG_WIDTH(TAG_WIDTH)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready),
      .req_action(dltq_pkg::action_type'(req_tuser)),
      .req_delay(req_tdata[DELAY_WIDTH-1:0]),
      .req_key(req_tdata[DELAY_WIDTH+KEY_WIDTH-1:DELAY_WIDTH]),
      .req_tag(req_tdata[DELAY_WIDTH+KEY_WIDTH+TAG_WIDTH-1:DELAY_WIDTH+KEY_WIDTH]),
      .out_free(out_free), .emit_valid(emit_valid), .emit_last(emit_last),
      .emit_kind(emit_kind), .emit_key(emit_key), .emit_tag(emit_tag),
      .pending_count(pending_count),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_delta(wr_delta), .wr_key(wr_key),
      .wr_tag(wr_tag), .wr_link(wr_link), .rd_en(rd_en), .rd_addr(rd_addr),
      .rd_delta(rd_delta), .rd_key(rd_key), .rd_tag(rd_tag), .rd_link(rd_link)
   );

   dltq_mem #(
      .SLOTS(SLOTS), .DELAY_WIDTH(DELAY_WIDTH), .KEY_WIDTH(KEY_WIDTH), .TAG_WIDTH(TAG_WIDTH)
   ) u_mem (
      .clock(clock),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_delta(wr_delta), .wr_key(wr_key),
      .wr_tag(wr_tag), .wr_link(wr_link), .rd_en(rd_en), .rd_addr(rd_addr),
      .rd_delta(rd_delta), .rd_key(rd_key), .rd_tag(rd_tag), .rd_link(rd_link)
   );

   // output register
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = out_free ? emit_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit_valid) begin
         rsp_last_ff <= emit_last;
         rsp_kind_ff <= emit_kind;
         rsp_key_ff  <= emit_key;
         rsp_tag_ff  <= emit_tag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = RDW'({rsp_tag_ff, rsp_key_ff});

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pending_count <= LW'(SLOTS))
      else $error("pending alarm count above slot count");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> out_free)
      else $error("item emitted into a full output register");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !emit_valid && !rd_en || req_tvalid)
      else $error("activity while waiting for an item");

endmodule

`default_nettype wire
